[rtl/xorshift_charset_generator_macros.svh]
// Assertion macros for the xorshift character generator.
// Included by the RTL files that carry concurrent assertions; no dependencies.
`ifndef XORSHIFT_CHARSET_GENERATOR_MACROS_SVH
`define XORSHIFT_CHARSET_GENERATOR_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define XCG_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define XCG_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/xcg_pkg.sv]
// Shared types, constants and the xorshift step for the character generator.
// No dependencies; compiled first.
package xcg_pkg;

  localparam int ALPHABET_DEPTH = 96;
  localparam int ADDR_W         = $clog2(ALPHABET_DEPTH);

  localparam int MODE_W = 2;
  localparam int SEED_W = 64;
  localparam int IDX_W  = 7;
  localparam int CHAR_W = 7;
  localparam int LEN_W  = 7;
  localparam int DIV_W  = LEN_W + 1;

  localparam logic [LEN_W-1:0] LEN_RESET = 7'd70;
  localparam logic [SEED_W-1:0] STATE_RESET = 64'd1;

  // remainder digits folded per cycle in the modulo unit
  localparam int DIGITS     = 4;
  localparam int DIV_CYCLES = SEED_W / DIGITS;
  localparam int CNT_W      = $clog2(DIV_CYCLES);

  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  localparam logic [MODE_W-1:0] MODE_GEN   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_SEED  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_WRITE = 2'd2;

  typedef enum logic [1:0] {
    OP_GEN,
    OP_SEED,
    OP_WRITE
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [SEED_W-1:0] seed;
    logic [IDX_W-1:0]  idx;
    logic [CHAR_W-1:0] chr;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_READ,
    ST_LOAD
  } st_t;

  function automatic logic [SEED_W-1:0] xs_advance(input logic [SEED_W-1:0] s);
    logic [SEED_W-1:0] v;
    v = s ^ (s << 13);
    v = v ^ (v >> 7);
    v = v ^ (v << 17);
    return v;
  endfunction

endpackage

[rtl/xcg_if.sv]
// Request and result channel interfaces for the character generator.
// Depends on xcg_pkg.
interface xcg_in_if import xcg_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] mode;
  logic [SEED_W-1:0] seed_value;
  logic [IDX_W-1:0]  entry_index;
  logic [CHAR_W-1:0] entry_char;

  modport source (output valid, mode, seed_value, entry_index, entry_char, input ready);
  modport sink   (input valid, mode, seed_value, entry_index, entry_char, output ready);
endinterface

interface xcg_out_if import xcg_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] character;

  modport source (output valid, character, input ready);
  modport sink   (input valid, character, output ready);
endinterface

[rtl/xcg_front.sv]
// Front end: takes requests, decodes the mode, drops no-op requests.
// Depends on xcg_pkg and xcg_if.
module xcg_front import xcg_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  xcg_in_if.sink  in_ch,
  output logic    push,
  output cmd_t    push_cmd,
  input  q_stat_t q_stat
);

  logic hold_v_r, hold_v_nxt;
  cmd_t hold_r;
  cmd_t dec;
  logic dec_v;
  logic take;

  // mode 3 and writes past the store are accepted and dropped here
  always_comb begin
    dec.seed = in_ch.seed_value;
    dec.idx  = in_ch.entry_index;
    dec.chr  = in_ch.entry_char;
    dec.op   = OP_GEN;
    dec_v    = 1'b0;
    case (in_ch.mode)
      MODE_GEN: begin
        dec.op = OP_GEN;
        dec_v  = 1'b1;
      end
      MODE_SEED: begin
        dec.op = OP_SEED;
        dec_v  = 1'b1;
      end
      MODE_WRITE: begin
        dec.op = OP_WRITE;
        dec_v  = ({1'b0, in_ch.entry_index} < (IDX_W+1)'(ALPHABET_DEPTH));
      end
      default: begin
        dec_v = 1'b0;
      end
    endcase
  end

  assign push        = hold_v_r && !q_stat.full;
  assign push_cmd    = hold_r;
  assign in_ch.ready = !hold_v_r || !q_stat.full;
  assign take        = in_ch.valid && in_ch.ready;

  always_comb begin
    hold_v_nxt = hold_v_r;
    if (push) begin
      hold_v_nxt = 1'b0;
    end
    if (take) begin
      hold_v_nxt = dec_v;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_v_r <= 1'b0;
    end else begin
      hold_v_r <= hold_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      hold_r <= dec;
    end
  end

endmodule

[rtl/xcg_fifo.sv]
// Short command queue between the front end and the execution back end.
// Depends on xcg_pkg.
module xcg_fifo import xcg_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  cmd_t    push_cmd,
  input  logic    pop,
  output cmd_t    pop_cmd,
  output q_stat_t q_stat
);

  cmd_t               ent_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_r, wr_nxt;
  logic [Q_PTR_W-1:0] rd_r, rd_nxt;
  logic [Q_CNT_W-1:0] cnt_r, cnt_nxt;
  logic               do_push, do_pop;

  function automatic logic [Q_PTR_W-1:0] ptr_inc(input logic [Q_PTR_W-1:0] p);
    return (p == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign q_stat.full  = (cnt_r == Q_CNT_W'(Q_DEPTH));
  assign q_stat.empty = (cnt_r == '0);
  assign do_push      = push && !q_stat.full;
  assign do_pop       = pop && !q_stat.empty;
  assign pop_cmd      = ent_r[rd_r];

  always_comb begin
    wr_nxt  = do_push ? ptr_inc(wr_r) : wr_r;
    rd_nxt  = do_pop ? ptr_inc(rd_r) : rd_r;
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      ent_r[wr_r] <= push_cmd;
    end
  end

endmodule

[rtl/xcg_back.sv]
// Back end: generator state, modulo unit, alphabet memory, result register.
// Depends on xcg_pkg, xcg_if and the assertion macro header.
`include "xorshift_charset_generator_macros.svh"

module xcg_back import xcg_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  cmd_t             cmd,
  input  q_stat_t          q_stat,
  output logic             pop,
  input  logic             cfg_we,
  input  logic [LEN_W-1:0] cfg_wdata,
  xcg_out_if.source        out_ch
);

  st_t               st_r, st_nxt;
  logic [SEED_W-1:0] gen_r;
  logic [SEED_W-1:0] div_q_r;
  logic [LEN_W-1:0]  rem_r, rem_step;
  logic [CNT_W-1:0]  cnt_r;
  logic [LEN_W-1:0]  len_r;
  logic [DIV_W-1:0]  len_eff;
  logic [CHAR_W-1:0] mem [ALPHABET_DEPTH];
  logic [CHAR_W-1:0] rdata_r;
  logic [CHAR_W-1:0] out_char_r;
  logic              out_v_r;
  logic              out_free;
  logic              cnt_last;
  logic              mem_we, mem_re, seed_ld, gen_go, div_run, out_load;

  assign out_free = !out_v_r || out_ch.ready;
  assign cnt_last = (cnt_r == CNT_W'(DIV_CYCLES - 1));

  // zero length acts as one, lengths past the store saturate
  always_comb begin
    if (len_r == '0) begin
      len_eff = DIV_W'(1);
    end else if ({1'b0, len_r} > DIV_W'(ALPHABET_DEPTH)) begin
      len_eff = DIV_W'(ALPHABET_DEPTH);
    end else begin
      len_eff = {1'b0, len_r};
    end
  end

  // restoring remainder, DIGITS quotient bits per cycle, MSB first
  always_comb begin
    logic [DIV_W-1:0] t;
    logic [LEN_W-1:0] r;
    r = rem_r;
    for (int i = 0; i < DIGITS; i++) begin
      t = {r, div_q_r[SEED_W-1-i]};
      if (t >= len_eff) begin
        t = t - len_eff;
      end
      r = t[LEN_W-1:0];
    end
    rem_step = r;
  end

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_IDLE: begin
        if (!q_stat.empty && cmd.op == OP_GEN) begin
          st_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (cnt_last) begin
          st_nxt = ST_READ;
        end
      end
      ST_READ: begin
        st_nxt = ST_LOAD;
      end
      ST_LOAD: begin
        if (out_free) begin
          st_nxt = ST_IDLE;
        end
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    pop      = 1'b0;
    mem_we   = 1'b0;
    mem_re   = 1'b0;
    seed_ld  = 1'b0;
    gen_go   = 1'b0;
    div_run  = 1'b0;
    out_load = 1'b0;
    case (st_r)
      ST_IDLE: begin
        if (!q_stat.empty) begin
          pop = 1'b1;
          case (cmd.op)
            OP_GEN:   gen_go  = 1'b1;
            OP_SEED:  seed_ld = 1'b1;
            OP_WRITE: mem_we  = 1'b1;
            default:  ;
          endcase
        end
      end
      ST_DIV:  div_run = 1'b1;
      ST_READ: mem_re = 1'b1;
      ST_LOAD: out_load = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= ST_IDLE;
      gen_r   <= STATE_RESET;
      len_r   <= LEN_RESET;
      out_v_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (cfg_we) begin
        len_r <= cfg_wdata;
      end
      if (seed_ld) begin
        gen_r <= cmd.seed;
      end else if (gen_go) begin
        gen_r <= xs_advance(gen_r);
      end
      if (out_load) begin
        out_v_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (gen_go) begin
      div_q_r <= xs_advance(gen_r);
      rem_r   <= '0;
      cnt_r   <= '0;
    end else if (div_run) begin
      div_q_r <= div_q_r << DIGITS;
      rem_r   <= rem_step;
      cnt_r   <= cnt_r + 1'b1;
    end
    if (out_load) begin
      out_char_r <= rdata_r;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[cmd.idx[ADDR_W-1:0]] <= cmd.chr;
    end
    if (mem_re) begin
      rdata_r <= mem[rem_r[ADDR_W-1:0]];
    end
  end

  assign out_ch.valid     = out_v_r;
  assign out_ch.character = out_char_r;

  `XCG_ASSERT_NOW(a_rem_below_len, clk, rst_n, st_r == ST_DIV || st_r == ST_READ,
    {1'b0, rem_r} < len_eff, "remainder not below alphabet length")
  `XCG_ASSERT_NEXT(a_gen_starts_div, clk, rst_n, gen_go,
    st_r == ST_DIV && cnt_r == '0, "generate request did not start modulo unit")
  `XCG_ASSERT_NEXT(a_load_to_idle, clk, rst_n, out_load,
    out_v_r && st_r == ST_IDLE, "result load did not present a result")

endmodule

[rtl/xorshift_charset_generator.sv]
// Top level of the xorshift random character generator.
// Depends on xcg_pkg, xcg_if, xcg_front, xcg_fifo and xcg_back.

// Random character generator. A 64-bit xorshift state (shifts 13, 7, 17,
// reset value 1) is advanced once per generate request, reduced modulo the
// alphabet length and used to index a 96-entry store of 7-bit characters.
// Requests: mode 0 generates one character (one result), mode 1 loads the
// seed, mode 2 writes one alphabet slot; neither of the last two gives a
// result, and mode 3 or a slot index past the store is taken and dropped.
// A zero seed stays zero. Slots must be written before a generate can land
// on them; an unwritten slot returns an arbitrary code.
// cfg_wdata sets the alphabet length (reset 70); 0 acts as 1 and values past
// 96 saturate to 96. Write it only while no request is in flight.
// A generate request holds the back end while it pops and steps the state,
// runs the modulo unit folding 4 bits a cycle, reads the alphabet memory
// and loads the result register once the output is free; seed loads and
// slot writes finish as they are popped. A front holding stage and a
// two-deep queue take requests in while a generate runs or a result waits.
module xorshift_charset_generator import xcg_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  xcg_in_if.sink           in_ch,
  xcg_out_if.source        out_ch,
  input  logic             cfg_we,
  input  logic [LEN_W-1:0] cfg_wdata
);

  // front -> queue
  logic    push;
  cmd_t    push_cmd;
  // queue -> back
  logic    pop;
  cmd_t    pop_cmd;
  q_stat_t q_stat;

  // decode and hold one request
  xcg_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .push     (push),
    .push_cmd (push_cmd),
    .q_stat   (q_stat)
  );

  // decouples request intake from execution
  xcg_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .pop_cmd  (pop_cmd),
    .q_stat   (q_stat)
  );

  // state, modulo, alphabet lookup and result register
  xcg_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (pop_cmd),
    .q_stat    (q_stat),
    .pop       (pop),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .out_ch    (out_ch)
  );

endmodule
